/* rtl/rrfc_pkg.sv */
// ---------------------------------------------------------------------------
// rrfc_pkg
// Constants and status codes for the reader response frame checker.
// ---------------------------------------------------------------------------
`default_nettype none

package rrfc_pkg;

	// frame framing bytes
	localparam logic [7:0] START_BYTE = 8'hEA;
	localparam logic [7:0] TRAIL_HI   = 8'h90;
	localparam logic [7:0] TRAIL_LO   = 8'h00;

	// frame position counter
	localparam int unsigned COUNT_W = 17;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// fixed positions inside the frame
	localparam logic [COUNT_W-1:0] POS_START  = 17'd0;
	localparam logic [COUNT_W-1:0] POS_CLASS  = 17'd1;
	localparam logic [COUNT_W-1:0] POS_SUB    = 17'd2;
	localparam logic [COUNT_W-1:0] POS_LEN_HI = 17'd3;
	localparam logic [COUNT_W-1:0] POS_LEN_LO = 17'd4;
	localparam logic [COUNT_W-1:0] POS_DATA   = 17'd5;

	// frame overhead around the data section
	localparam logic [COUNT_W:0] FRAME_OVERHEAD = 18'd7;

	// reader error data lengths
	localparam logic [15:0] LEN_CODE1 = 16'd1;
	localparam logic [15:0] LEN_CODE2 = 16'd2;

	// status codes
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_HEADER  = 3'd1,
		ST_TRAILER = 3'd2,
		ST_TYPE    = 3'd3,
		ST_LENGTH  = 3'd4,
		ST_READER  = 3'd5,
		ST_LRC     = 3'd6
	} status_t;

	// register indexes
	localparam logic [1:0] REG_CLASS    = 2'd0;
	localparam logic [1:0] REG_SUBTYPE  = 2'd1;
	localparam logic [1:0] REG_CHECKLRC = 2'd2;

	// register reset values
	localparam logic [7:0] CLASS_RST    = 8'h05;
	localparam logic [7:0] SUBTYPE_RST  = 8'h01;
	localparam logic       CHECKLRC_RST = 1'b1;

endpackage

`default_nettype wire

/* rtl/rrfc_if.sv */
// ---------------------------------------------------------------------------
// rrfc_if
// Valid/ready channels for received bytes and per-byte check results.
// ---------------------------------------------------------------------------
`default_nettype none

// received byte channel
interface rrfc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       last_byte;

	modport source (output valid, output rx_byte, output last_byte, input ready);
	modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

// result channel
interface rrfc_out_if;
	logic        valid;
	logic        ready;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic [15:0] payload_index;
	logic        frame_done;
	logic [2:0]  status;
	logic [15:0] reader_code;
	logic [31:0] lead_word;

	modport source (
		output valid, output payload_valid, output payload_byte, output payload_index,
		output frame_done, output status, output reader_code, output lead_word,
		input ready
	);
	modport sink (
		input valid, input payload_valid, input payload_byte, input payload_index,
		input frame_done, input status, input reader_code, input lead_word,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/reader_response_frame_checker_top.sv */
// ---------------------------------------------------------------------------
// reader_response_frame_checker_top
// Byte-wise checker for framed reader responses with XOR LRC.
// ---------------------------------------------------------------------------
// One request carries one received frame byte and produces exactly one result
// in the next cycle: data bytes come out with their index, and the byte marked
// last also carries the frame status, reader error code and lead word. A new
// byte is taken every cycle while the result register is empty or being
// drained; the frame state (position counter, length, LRC and lead word) is
// updated as each byte is taken. Type bytes are compared with the register
// values current when each byte arrives.
`default_nettype none

module reader_response_frame_checker_top (
	input  wire         clk,
	input  wire         arst_n,
	rrfc_in_if.sink     in_ch,
	rrfc_out_if.source  out_ch,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import rrfc_pkg::*;

	// configuration registers
	logic [7:0] class_q;
	logic [7:0] subtype_q;
	logic       check_lrc_q;

	// frame state
	logic [COUNT_W-1:0] byte_count_q;
	logic               header_bad_q;
	logic               type_bad_q;
	logic [7:0]         length_high_q;
	logic [15:0]        data_length_q;
	logic [7:0]         lrc_q;
	logic [7:0]         prev_byte_q;
	logic [31:0]        lead_q;

	// result register
	logic        out_valid_q;
	logic        pvalid_q;
	logic [7:0]  pbyte_q;
	logic [15:0] pindex_q;
	logic        done_q;
	status_t     status_q;
	logic [15:0] code_q;
	logic [31:0] lead_word_q;

	// next-state and result logic
	logic               accept;
	logic [7:0]         b;
	logic [COUNT_W-1:0] pos;
	logic [COUNT_W-1:0] idx;
	logic               in_data;
	logic               header_bad_n;
	logic               type_bad_n;
	logic [7:0]         length_high_n;
	logic [15:0]        data_length_n;
	logic [7:0]         lrc_n;
	logic [31:0]        lead_n;
	logic               trailer_ok;
	logic [COUNT_W:0]   total;
	logic [COUNT_W:0]   expect_total;
	status_t            status_n;
	logic [15:0]        code_n;

	assign pready = 1'b1;

	// register write and read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_q     <= CLASS_RST;
			subtype_q   <= SUBTYPE_RST;
			check_lrc_q <= CHECKLRC_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_CLASS:    class_q     <= pwdata[7:0];
				REG_SUBTYPE:  subtype_q   <= pwdata[7:0];
				REG_CHECKLRC: check_lrc_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_CLASS:    prdata = {24'd0, class_q};
			REG_SUBTYPE:  prdata = {24'd0, subtype_q};
			REG_CHECKLRC: prdata = {31'd0, check_lrc_q};
			default:      prdata = 32'd0;
		endcase
	end

	// handshake: take a byte when the result register is free or draining
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	// decode the byte against the frame position
	always_comb begin
		b             = in_ch.rx_byte;
		pos           = byte_count_q;
		idx           = pos - POS_DATA;
		header_bad_n  = header_bad_q;
		type_bad_n    = type_bad_q;
		length_high_n = length_high_q;
		data_length_n = data_length_q;
		lrc_n         = lrc_q;
		lead_n        = lead_q;
		in_data       = 1'b0;
		case (pos)
			POS_START:  header_bad_n = (b != START_BYTE);
			POS_CLASS:  if (b != class_q) type_bad_n = 1'b1;
			POS_SUB:    if (b != subtype_q) type_bad_n = 1'b1;
			POS_LEN_HI: length_high_n = b;
			POS_LEN_LO: data_length_n = {length_high_q, b};
			default: begin
				if (pos != COUNT_MAX && idx < {1'b0, data_length_q}) begin
					in_data = 1'b1;
					lrc_n   = lrc_q ^ b;
					case (idx[1:0])
						2'd0: if (idx[COUNT_W-1:2] == '0) lead_n[7:0]   = lead_q[7:0]   | b;
						2'd1: if (idx[COUNT_W-1:2] == '0) lead_n[15:8]  = lead_q[15:8]  | b;
						2'd2: if (idx[COUNT_W-1:2] == '0) lead_n[23:16] = lead_q[23:16] | b;
						default: if (idx[COUNT_W-1:2] == '0) lead_n[31:24] = lead_q[31:24] | b;
					endcase
				end
			end
		endcase
	end

	// frame status, in priority order
	always_comb begin
		trailer_ok   = (pos != POS_START) && (prev_byte_q == TRAIL_HI) && (b == TRAIL_LO);
		total        = {1'b0, pos} + {{COUNT_W{1'b0}}, 1'b1};
		expect_total = {2'b00, data_length_n} + FRAME_OVERHEAD;
		status_n     = ST_OK;
		code_n       = 16'd0;
		if (header_bad_n) begin
			status_n = ST_HEADER;
		end else if (!trailer_ok) begin
			status_n = ST_TRAILER;
		end else if (type_bad_n || pos < POS_SUB) begin
			status_n = ST_TYPE;
		end else if (check_lrc_q) begin
			if (pos == COUNT_MAX || total != expect_total) begin
				status_n = ST_LENGTH;
			end else if (data_length_n == LEN_CODE1) begin
				status_n = ST_READER;
				code_n   = {8'd0, lead_n[7:0]};
			end else if (data_length_n == LEN_CODE2) begin
				status_n = ST_READER;
				code_n   = lead_n[15:0];
			end else if (data_length_n == 16'd0 || lrc_n != 8'd0) begin
				status_n = ST_LRC;
			end
		end
	end

	// frame state update, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			header_bad_q  <= 1'b0;
			type_bad_q    <= 1'b0;
			length_high_q <= 8'd0;
			data_length_q <= 16'd0;
			lrc_q         <= 8'd0;
			prev_byte_q   <= 8'd0;
			lead_q        <= 32'd0;
		end else if (accept) begin
			if (in_ch.last_byte) begin
				byte_count_q  <= '0;
				header_bad_q  <= 1'b0;
				type_bad_q    <= 1'b0;
				length_high_q <= 8'd0;
				data_length_q <= 16'd0;
				lrc_q         <= 8'd0;
				prev_byte_q   <= 8'd0;
				lead_q        <= 32'd0;
			end else begin
				if (byte_count_q != COUNT_MAX) byte_count_q <= byte_count_q + 1'b1;
				header_bad_q  <= header_bad_n;
				type_bad_q    <= type_bad_n;
				length_high_q <= length_high_n;
				data_length_q <= data_length_n;
				lrc_q         <= lrc_n;
				prev_byte_q   <= b;
				lead_q        <= lead_n;
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ch.ready) begin
			out_valid_q <= in_ch.valid;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pvalid_q    <= in_data;
			pbyte_q     <= in_data ? b : 8'd0;
			pindex_q    <= in_data ? idx[15:0] : 16'd0;
			done_q      <= in_ch.last_byte;
			status_q    <= in_ch.last_byte ? status_n : ST_OK;
			code_q      <= in_ch.last_byte ? code_n : 16'd0;
			lead_word_q <= in_ch.last_byte ? lead_n : 32'd0;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.payload_valid = pvalid_q;
	assign out_ch.payload_byte  = pbyte_q;
	assign out_ch.payload_index = pindex_q;
	assign out_ch.frame_done    = done_q;
	assign out_ch.status        = status_q;
	assign out_ch.reader_code   = code_q;
	assign out_ch.lead_word     = lead_word_q;

endmodule

`default_nettype wire
